// ----- hw/rtl/satlb_pkg.sv -----
// Package: shared types and constants of the set-associative TLB.
`default_nettype none
package satlb_pkg;
  localparam int SETS_DEF = 16;
  localparam int WAYS_DEF = 4;
  localparam int VPN_W = 20;
  localparam int VA_W = 32;
  localparam int ASID_W = 9;
  localparam int PPN_W = 22;
  localparam int FLG_W = 7;
  localparam int KIND_W = 3;
  localparam int SP_SHIFT = 10;
  localparam int PG_SHIFT = 12;

  localparam logic [KIND_W-1:0] K_LOOKUP = 3'd0;
  localparam logic [KIND_W-1:0] K_FILL   = 3'd1;
  localparam logic [KIND_W-1:0] K_FALL   = 3'd2;
  localparam logic [KIND_W-1:0] K_FASID  = 3'd3;
  localparam logic [KIND_W-1:0] K_FADDR  = 3'd4;
  localparam logic [KIND_W-1:0] K_FAA    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VPN_W-1:0]  page;
    logic [ASID_W-1:0] asid;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
    logic              glob;
    logic              sp;
  } cmd_t;

  typedef struct packed {
    logic [VPN_W-1:0]  vpn;
    logic [ASID_W-1:0] asid;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
    logic              glob;
    logic              sp;
  } slot_t;

  function automatic logic [2:0] tree_touch(logic [2:0] t, logic [1:0] w);
    logic [2:0] r;
    case (w)
      2'd0: r = {2'b00, t[0]};
      2'd1: r = {2'b01, t[0]};
      2'd2: r = {1'b1, t[1], 1'b0};
      default: r = {1'b1, t[1], 1'b1};
    endcase
    return r;
  endfunction

  function automatic logic [1:0] tree_victim(logic [2:0] t);
    logic [1:0] r;
    if (t[2]) r = t[1] ? 2'd0 : 2'd1;
    else r = t[0] ? 2'd2 : 2'd3;
    return r;
  endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/satlb_front.sv -----
// Front end: captures commands, normalizes the page, and queues them.
`default_nettype none
module satlb_front #(
  parameter int DEPTH = 2
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic [satlb_pkg::KIND_W-1:0] kind,
  input  wire logic [satlb_pkg::VPN_W-1:0]  vpn,
  input  wire logic [satlb_pkg::VA_W-1:0]   va,
  input  wire logic [satlb_pkg::ASID_W-1:0] asid,
  input  wire logic [satlb_pkg::PPN_W-1:0]  ppn,
  input  wire logic [satlb_pkg::FLG_W-1:0]  flags,
  input  wire logic                        glob,
  input  wire logic                        sp,
  output logic                             full,
  output logic                             empty,
  input  wire logic                        pop,
  output satlb_pkg::cmd_t                  head
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  satlb_pkg::cmd_t q_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0] cnt_r;
  satlb_pkg::cmd_t c;

  always_comb begin
    c.kind = kind;
    c.page = (kind == satlb_pkg::K_FADDR || kind == satlb_pkg::K_FAA) ?
             va[satlb_pkg::VA_W-1:satlb_pkg::PG_SHIFT] : vpn;
    c.asid = asid;
    c.ppn = ppn;
    c.flags = flags;
    c.glob = glob;
    c.sp = sp;
  end

  assign full = (cnt_r == (PW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= c;
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == PW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop) rp_r <= (rp_r == PW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/satlb_back.sv -----
// Back end: set arrays, match, fill, PLRU and flush sequencing.
`default_nettype none
module satlb_back #(
  parameter int SETS = satlb_pkg::SETS_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            empty,
  input  satlb_pkg::cmd_t      head,
  output logic                 pop,
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [satlb_pkg::PPN_W-1:0] out_ppn,
  output logic [satlb_pkg::FLG_W-1:0] out_flags,
  output logic                 out_glob,
  output logic                 out_sp
);
  localparam int SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAYS = satlb_pkg::WAYS_DEF;
  localparam int SP = satlb_pkg::SP_SHIFT;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WALK} st_t;
  st_t st_r;
  logic [SW-1:0] wk_r;

  logic [WAYS-1:0] vld_r [SETS];
  logic [2:0] tree_r [SETS];
  satlb_pkg::slot_t pay_r [SETS][WAYS];
  satlb_pkg::slot_t e_r [WAYS];

  logic [SW-1:0] hset, s, rd_s;
  logic [WAYS-1:0] pm, am, hitv, exv;
  logic [1:0] hw, pick;
  logic any_hit, any_ex, any_inv;
  logic [1:0] inv_w;
  satlb_pkg::slot_t hs;
  logic ex, lk_hit;

  always_comb begin
    hset = SW'(head.page % SETS);
    if (st_r == S_WALK) s = wk_r;
    else s = hset;
    // set read in this cycle, used by the next one
    if (st_r == S_WALK) rd_s = (wk_r == SW'(SETS-1)) ? '0 : wk_r + 1'b1;
    else if (st_r == S_EXEC && head.kind == satlb_pkg::K_FASID) rd_s = '0;
    else rd_s = hset;
    for (int w = 0; w < WAYS; w++) begin
      pm[w] = e_r[w].sp ? (e_r[w].vpn[satlb_pkg::VPN_W-1:SP] ==
                           head.page[satlb_pkg::VPN_W-1:SP])
                        : (e_r[w].vpn == head.page);
      am[w] = e_r[w].glob || (e_r[w].asid == head.asid);
      hitv[w] = vld_r[s][w] && pm[w] && am[w];
      exv[w] = vld_r[s][w] && (e_r[w].vpn == head.page) && am[w];
    end
    any_hit = |hitv;
    hw = hitv[0] ? 2'd0 : hitv[1] ? 2'd1 : hitv[2] ? 2'd2 : 2'd3;
    any_ex = |exv;
    any_inv = ~&vld_r[s];
    inv_w = !vld_r[s][0] ? 2'd0 : !vld_r[s][1] ? 2'd1 : !vld_r[s][2] ? 2'd2 : 2'd3;
    if (any_ex) pick = exv[0] ? 2'd0 : exv[1] ? 2'd1 : exv[2] ? 2'd2 : 2'd3;
    else if (any_inv) pick = inv_w;
    else pick = satlb_pkg::tree_victim(tree_r[s]);
    hs = e_r[hw];
    ex = (st_r == S_EXEC);
    lk_hit = ex && head.kind == satlb_pkg::K_LOOKUP && any_hit;
    pop = (ex && head.kind != satlb_pkg::K_FASID) ||
          (st_r == S_WALK && wk_r == SW'(SETS-1));
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < WAYS; w++) e_r[w] <= pay_r[rd_s][w];
    if (ex && head.kind == satlb_pkg::K_FILL) begin
      if (!any_ex) pay_r[s][pick].vpn <= head.page;
      pay_r[s][pick].asid <= head.asid;
      pay_r[s][pick].ppn <= head.ppn;
      pay_r[s][pick].flags <= head.flags;
      pay_r[s][pick].glob <= head.glob;
      pay_r[s][pick].sp <= head.sp;
    end
    out_ppn <= lk_hit ? hs.ppn : '0;
    out_flags <= lk_hit ? hs.flags : '0;
    out_glob <= lk_hit ? hs.glob : 1'b0;
    out_sp <= lk_hit ? hs.sp : 1'b0;
    if (!rst_n) begin
      st_r <= S_IDLE;
      wk_r <= '0;
      out_valid <= 1'b0;
      out_hit <= 1'b0;
      for (int i = 0; i < SETS; i++) begin
        vld_r[i] <= '0;
        tree_r[i] <= '0;
      end
    end else begin
      out_valid <= pop;
      out_hit <= lk_hit;
      case (st_r)
        S_IDLE: if (!empty) st_r <= S_EXEC;
        S_EXEC: begin
          st_r <= (head.kind == satlb_pkg::K_FASID) ? S_WALK : S_IDLE;
          case (head.kind)
            satlb_pkg::K_LOOKUP:
              if (any_hit) tree_r[s] <= satlb_pkg::tree_touch(tree_r[s], hw);
            satlb_pkg::K_FILL: begin
              vld_r[s][pick] <= 1'b1;
              tree_r[s] <= satlb_pkg::tree_touch(tree_r[s], pick);
            end
            satlb_pkg::K_FALL:
              for (int i = 0; i < SETS; i++) begin
                vld_r[i] <= '0;
                tree_r[i] <= '0;
              end
            satlb_pkg::K_FASID: wk_r <= '0;
            satlb_pkg::K_FADDR: vld_r[s] <= vld_r[s] & ~(vld_r[s] & pm);
            satlb_pkg::K_FAA: vld_r[s] <= vld_r[s] & ~hitv;
            default: ;
          endcase
        end
        S_WALK: begin
          for (int w = 0; w < WAYS; w++)
            if (vld_r[s][w] && !e_r[w].glob && e_r[w].asid == head.asid)
              vld_r[s][w] <= 1'b0;
          if (wk_r == SW'(SETS-1)) st_r <= S_IDLE;
          else wk_r <= wk_r + 1'b1;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/set_assoc_tlb_plru.sv -----
// Top level: 4-way set-associative TLB with tree pseudo-LRU.
//   channel | ports              | handshake
//   input   | start, in_*        | accepted when start && !busy
//   result  | out_strobe, out_*  | one cycle, no back-pressure
// One result per command.
// The back end reads the set in S_IDLE and executes in the next cycle, in
// S_EXEC, so lookup, fill and all flushes but the ASID flush take S_IDLE and
// S_EXEC only; the ASID flush then walks one set per cycle in S_WALK.
// busy is high while the two-entry command queue is full.
// Synchronous active-low reset clears valid bits and PLRU trees.
`default_nettype none
module set_assoc_tlb_plru #(
  parameter int SETS = satlb_pkg::SETS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [satlb_pkg::KIND_W-1:0] in_kind,
  input  wire logic [satlb_pkg::VPN_W-1:0]  in_virtual_page,
  input  wire logic [satlb_pkg::VA_W-1:0]   in_virtual_address,
  input  wire logic [satlb_pkg::ASID_W-1:0] in_asid,
  input  wire logic [satlb_pkg::PPN_W-1:0]  in_physical_page,
  input  wire logic [satlb_pkg::FLG_W-1:0]  in_access_flags,
  input  wire logic                        in_global_mapping,
  input  wire logic                        in_superpage,
  output logic                             out_strobe,
  output logic                             out_hit,
  output logic [satlb_pkg::PPN_W-1:0]      out_hit_physical_page,
  output logic [satlb_pkg::FLG_W-1:0]      out_hit_flags,
  output logic                             out_hit_global,
  output logic                             out_hit_superpage
);
  logic full, empty, pop;
  satlb_pkg::cmd_t head;
  assign busy = full;

  satlb_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .push(start && !full), .kind(in_kind), .vpn(in_virtual_page),
    .va(in_virtual_address), .asid(in_asid), .ppn(in_physical_page),
    .flags(in_access_flags), .glob(in_global_mapping), .sp(in_superpage),
    .full, .empty, .pop, .head
  );

  satlb_back #(.SETS(SETS)) u_back (
    .clk, .rst_n, .empty, .head, .pop, .out_valid(out_strobe), .out_hit,
    .out_ppn(out_hit_physical_page), .out_flags(out_hit_flags),
    .out_glob(out_hit_global), .out_sp(out_hit_superpage)
  );
endmodule
`default_nettype wire

// ----- hw/rtl/satlb_checker.sv -----
// Port-level checker for the TLB, bound to the top level.
`default_nettype none
module satlb_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_strobe,
  input wire logic out_hit,
  input wire logic [satlb_pkg::PPN_W-1:0] out_hit_physical_page,
  input wire logic [satlb_pkg::FLG_W-1:0] out_hit_flags,
  input wire logic out_hit_global,
  input wire logic out_hit_superpage
);
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_strobe && !busy)
    else $error("not idle after reset");
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    !out_hit |-> out_hit_physical_page == '0 && out_hit_flags == '0 &&
    !out_hit_global && !out_hit_superpage) else $error("miss fields nonzero");
  a_hs: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> out_strobe) else $error("hit without strobe");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !start && !busy |=> !busy) else $error("busy without a transaction");
endmodule

bind set_assoc_tlb_plru satlb_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe, .out_hit, .out_hit_physical_page,
  .out_hit_flags, .out_hit_global, .out_hit_superpage
);
`default_nettype wire

// ----- tb/sv/testbench.sv -----
// Testbench: directed table and random command streams for the set-associative TLB.
`timescale 1ns / 1ps
module testbench;
  localparam int SETS_DEF = satlb_pkg::SETS_DEF;
  localparam int WAYS_DEF = satlb_pkg::WAYS_DEF;
  localparam int KIND_W = satlb_pkg::KIND_W;
  localparam int VPN_W = satlb_pkg::VPN_W;
  localparam int VA_W = satlb_pkg::VA_W;
  localparam int ASID_W = satlb_pkg::ASID_W;
  localparam int PPN_W = satlb_pkg::PPN_W;
  localparam int FLG_W = satlb_pkg::FLG_W;
  localparam logic [KIND_W-1:0] K_LOOKUP = satlb_pkg::K_LOOKUP;
  localparam logic [KIND_W-1:0] K_FILL = satlb_pkg::K_FILL;
  localparam logic [KIND_W-1:0] K_FALL = satlb_pkg::K_FALL;
  localparam logic [KIND_W-1:0] K_FASID = satlb_pkg::K_FASID;
  localparam logic [KIND_W-1:0] K_FADDR = satlb_pkg::K_FADDR;
  localparam logic [KIND_W-1:0] K_FAA = satlb_pkg::K_FAA;

  localparam logic [KIND_W-1:0] K_RSVD6 = 3'd6;
  localparam logic [KIND_W-1:0] K_RSVD7 = 3'd7;
  localparam int N_RAND = 1930;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYC = 40;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [VPN_W-1:0]  page;
    logic [VA_W-1:0]   va;
    logic [ASID_W-1:0] asid;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
    logic              glob;
    logic              sp;
  } cmd_t;

  typedef struct {
    logic              hit;
    logic [PPN_W-1:0]  ppn;
    logic [FLG_W-1:0]  flags;
    logic              glob;
    logic              sp;
  } xlat_t;

  typedef struct {
    cmd_t  c;
    bit    typed;
    xlat_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic [VPN_W-1:0]  in_virtual_page = '0;
  logic [VA_W-1:0]   in_virtual_address = '0;
  logic [ASID_W-1:0] in_asid = '0;
  logic [PPN_W-1:0]  in_physical_page = '0;
  logic [FLG_W-1:0]  in_access_flags = '0;
  logic in_global_mapping = 1'b0;
  logic in_superpage = 1'b0;
  logic out_strobe, out_hit, out_hit_global, out_hit_superpage;
  logic [PPN_W-1:0] out_hit_physical_page;
  logic [FLG_W-1:0] out_hit_flags;

  set_assoc_tlb_plru dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_virtual_page(in_virtual_page),
    .in_virtual_address(in_virtual_address), .in_asid(in_asid),
    .in_physical_page(in_physical_page), .in_access_flags(in_access_flags),
    .in_global_mapping(in_global_mapping), .in_superpage(in_superpage),
    .out_strobe(out_strobe), .out_hit(out_hit),
    .out_hit_physical_page(out_hit_physical_page), .out_hit_flags(out_hit_flags),
    .out_hit_global(out_hit_global), .out_hit_superpage(out_hit_superpage)
  );

  initial forever #2 clk = ~clk;

  // shadow TLB state
  bit                tv [SETS_DEF][WAYS_DEF];
  logic [VPN_W-1:0]  tvpn [SETS_DEF][WAYS_DEF];
  logic [ASID_W-1:0] tasid [SETS_DEF][WAYS_DEF];
  logic [PPN_W-1:0]  tppn [SETS_DEF][WAYS_DEF];
  logic [FLG_W-1:0]  tflg [SETS_DEF][WAYS_DEF];
  logic              tglob [SETS_DEF][WAYS_DEF];
  logic              tsp [SETS_DEF][WAYS_DEF];
  logic [2:0]        tree [SETS_DEF];

  xlat_t xlat_q[$];
  row_t dir_tab[$];
  logic [VPN_W-1:0]  recent_page[$];
  logic [ASID_W-1:0] recent_asid[$];
  int errors = 0;
  int idle_cyc = 0;

  function automatic logic [2:0] mark_used(logic [2:0] t, int w);
    case (w)
      0: return t & 3'b001;
      1: return (t & 3'b001) | 3'b010;
      2: return (t & 3'b010) | 3'b100;
      default: return (t & 3'b010) | 3'b101;
    endcase
  endfunction

  function automatic int pick_victim(logic [2:0] t);
    if (t[2]) return t[1] ? 0 : 1;
    return t[0] ? 2 : 3;
  endfunction

  function automatic bit page_hit(int s, int w, logic [VPN_W-1:0] p);
    if (tsp[s][w]) return tvpn[s][w][19:10] == p[19:10];
    return tvpn[s][w] == p;
  endfunction

  function automatic xlat_t translate(cmd_t c);
    xlat_t r;
    int s, w, pick;
    logic [VPN_W-1:0] vap;
    r = '{1'b0, '0, '0, 1'b0, 1'b0};
    vap = c.va[31:12];
    case (c.kind)
      K_LOOKUP: begin
        s = int'(c.page[3:0]);
        for (w = 0; w < WAYS_DEF; w++) begin
          if (tv[s][w] && page_hit(s, w, c.page) && (tglob[s][w] || tasid[s][w] == c.asid)) begin
            tree[s] = mark_used(tree[s], w);
            r = '{1'b1, tppn[s][w], tflg[s][w], tglob[s][w], tsp[s][w]};
            break;
          end
        end
      end
      K_FILL: begin
        s = int'(c.page[3:0]);
        pick = -1;
        for (w = 0; w < WAYS_DEF && pick < 0; w++)
          if (tv[s][w] && tvpn[s][w] == c.page && (tglob[s][w] || tasid[s][w] == c.asid))
            pick = w;
        for (w = 0; w < WAYS_DEF && pick < 0; w++)
          if (!tv[s][w]) pick = w;
        if (pick < 0) pick = pick_victim(tree[s]);
        tv[s][pick] = 1'b1;
        tvpn[s][pick] = c.page;
        tasid[s][pick] = c.asid;
        tppn[s][pick] = c.ppn;
        tflg[s][pick] = c.flags;
        tglob[s][pick] = c.glob;
        tsp[s][pick] = c.sp;
        tree[s] = mark_used(tree[s], pick);
      end
      K_FALL: begin
        for (s = 0; s < SETS_DEF; s++) begin
          tree[s] = 3'b000;
          for (w = 0; w < WAYS_DEF; w++) tv[s][w] = 1'b0;
        end
      end
      K_FASID: begin
        for (s = 0; s < SETS_DEF; s++)
          for (w = 0; w < WAYS_DEF; w++)
            if (!tglob[s][w] && tasid[s][w] == c.asid) tv[s][w] = 1'b0;
      end
      K_FADDR, K_FAA: begin
        s = int'(vap[3:0]);
        for (w = 0; w < WAYS_DEF; w++)
          if (tv[s][w] && page_hit(s, w, vap) &&
              (c.kind == K_FADDR || tglob[s][w] || tasid[s][w] == c.asid))
            tv[s][w] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_row(logic [KIND_W-1:0] k, logic [VPN_W-1:0] p, logic [VA_W-1:0] va,
                                  logic [ASID_W-1:0] a, logic [PPN_W-1:0] pp,
                                  logic [FLG_W-1:0] f, logic g, logic sp,
                                  bit typed, xlat_t r);
    row_t x;
    x.c = '{k, p, va, a, pp, f, g, sp};
    x.typed = typed;
    x.r = r;
    dir_tab.push_back(x);
  endfunction

  function automatic logic [VPN_W-1:0] rand_page();
    logic [VPN_W-1:0] p;
    if ($urandom_range(0, 4) == 0) return VPN_W'($urandom);
    p[3:0] = 4'($urandom);
    p[9:4] = $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(0, 2));
    case ($urandom_range(0, 3))
      0: p[19:10] = 10'h3FF;
      1: p[19:10] = 10'($urandom);
      default: p[19:10] = 10'($urandom_range(0, 1));
    endcase
    return p;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r, j;
    c.page = rand_page();
    c.va = $urandom;
    c.asid = $urandom_range(0, 3) == 0 ? ASID_W'($urandom) : ASID_W'($urandom_range(0, 3));
    c.ppn = PPN_W'($urandom);
    c.flags = FLG_W'($urandom);
    c.glob = $urandom_range(0, 3) == 0;
    c.sp = $urandom_range(0, 4) == 0;
    r = $urandom_range(0, 99);
    if (r < 42) c.kind = K_LOOKUP;
    else if (r < 76) c.kind = K_FILL;
    else if (r < 78) c.kind = K_FALL;
    else if (r < 83) c.kind = K_FASID;
    else if (r < 90) c.kind = K_FADDR;
    else if (r < 97) c.kind = K_FAA;
    else c.kind = $urandom_range(0, 1) ? K_RSVD6 : K_RSVD7;
    // mostly aim at mappings that were recently installed
    if (recent_page.size() > 0 && $urandom_range(0, 3) != 0) begin
      j = $urandom_range(0, recent_page.size() - 1);
      c.page = recent_page[j];
      if ($urandom_range(0, 4) != 0) c.asid = recent_asid[j];
      if ($urandom_range(0, 5) == 0) c.page[9:0] = 10'($urandom);
      c.va = {c.page, 12'($urandom)};
    end
    if (c.kind == K_FILL) begin
      recent_page.push_back(c.page);
      recent_asid.push_back(c.asid);
      if (recent_page.size() > 24) begin
        void'(recent_page.pop_front());
        void'(recent_asid.pop_front());
      end
    end
    return c;
  endfunction

  int burst_left = 0;

  task automatic issue(cmd_t c, bit typed, xlat_t tr);
    xlat_t pr;
    int g;
    in_kind = c.kind;
    in_virtual_page = c.page;
    in_virtual_address = c.va;
    in_asid = c.asid;
    in_physical_page = c.ppn;
    in_access_flags = c.flags;
    in_global_mapping = c.glob;
    in_superpage = c.sp;
    start = 1'b1;
    do @(posedge clk); while (busy);
    pr = translate(c);
    xlat_q.push_back(typed ? tr : pr);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (g > 0) begin
        start = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    xlat_t e;
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cyc <= 0;
      else idle_cyc <= idle_cyc + 1;
      if (idle_cyc >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
      if (out_strobe) begin
        if (xlat_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errors++;
        end else begin
          e = xlat_q.pop_front();
          if (out_hit !== e.hit) begin
            $error("hit exp %0h act %0h", e.hit, out_hit); errors++;
          end
          if (out_hit_physical_page !== e.ppn) begin
            $error("hit_physical_page exp %0h act %0h", e.ppn, out_hit_physical_page);
            errors++;
          end
          if (out_hit_flags !== e.flags) begin
            $error("hit_flags exp %0h act %0h", e.flags, out_hit_flags); errors++;
          end
          if (out_hit_global !== e.glob) begin
            $error("hit_global exp %0h act %0h", e.glob, out_hit_global); errors++;
          end
          if (out_hit_superpage !== e.sp) begin
            $error("hit_superpage exp %0h act %0h", e.sp, out_hit_superpage); errors++;
          end
        end
      end
    end
  end

  initial begin
    xlat_t z, ones;
    int i, s, w;
    z = '{1'b0, '0, '0, 1'b0, 1'b0};
    ones = '{1'b1, '1, '1, 1'b1, 1'b1};
    for (s = 0; s < SETS_DEF; s++) begin
      tree[s] = 3'b000;
      for (w = 0; w < WAYS_DEF; w++) begin
        tv[s][w] = 1'b0; tvpn[s][w] = '0; tasid[s][w] = '0; tppn[s][w] = '0;
        tflg[s][w] = '0; tglob[s][w] = 1'b0; tsp[s][w] = 1'b0;
      end
    end
    add_row(K_LOOKUP, '1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, z);
    add_row(K_FILL, '1, '0, '1, '1, '1, 1'b1, 1'b1, 1'b1, z);
    add_row(K_LOOKUP, '1, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, ones);
    add_row(K_LOOKUP, 20'hFFC0F, '0, 9'h5, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_FILL, '0, '1, '0, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_LOOKUP, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_LOOKUP, '0, '0, 9'h1, '0, '0, 1'b0, 1'b0, 1'b0, z);
    // five fills into set 1 force a PLRU eviction
    add_row(K_FILL, 20'h00011, '0, 9'h1, 22'h111, 7'h11, 1'b0, 1'b0, 1'b1, z);
    add_row(K_FILL, 20'h00021, '0, 9'h1, 22'h222, 7'h22, 1'b0, 1'b0, 1'b1, z);
    add_row(K_FILL, 20'h00031, '0, 9'h2, 22'h333, 7'h33, 1'b1, 1'b0, 1'b1, z);
    add_row(K_FILL, 20'h00041, '0, 9'h1, 22'h444, 7'h44, 1'b0, 1'b0, 1'b1, z);
    add_row(K_LOOKUP, 20'h00021, '0, 9'h1, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_FILL, 20'h00051, '0, 9'h1, 22'h555, 7'h55, 1'b0, 1'b0, 1'b1, z);
    add_row(K_FILL, 20'h00021, '0, 9'h1, 22'h2AA, 7'h2A, 1'b0, 1'b1, 1'b1, z);
    add_row(K_LOOKUP, 20'h00021, '0, 9'h1, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_LOOKUP, 20'h00031, '0, 9'h1FF, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_FASID, '0, '0, 9'h1, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_LOOKUP, 20'h00041, '0, 9'h1, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_FADDR, '0, 32'hFFFFF000, '0, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_FAA, '0, 32'h00031ABC, 9'h7, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_LOOKUP, 20'h00031, '0, 9'h2, '0, '0, 1'b0, 1'b0, 1'b0, z);
    add_row(K_RSVD6, '1, '1, '1, '1, '1, 1'b1, 1'b1, 1'b1, z);
    add_row(K_RSVD7, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_FALL, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, z);
    add_row(K_LOOKUP, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1, z);

    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_tab[i]) issue(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
    for (i = 0; i < N_RAND; i++) issue(rand_cmd(), 1'b0, z);
    start = 1'b0;
    while (xlat_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ----- set_assoc_tlb_plru.f -----
hw/rtl/satlb_pkg.sv
hw/rtl/satlb_front.sv
hw/rtl/satlb_back.sv
hw/rtl/set_assoc_tlb_plru.sv
hw/rtl/satlb_checker.sv
tb/sv/testbench.sv
